// ----- hw/rtl/blesdt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// blesdt_pkg
// Shared types and codes of the scan device table: input function codes,
// event codes, register indexes, the queued command and the slot record.
// ----------------------------------------------------------------------------
package blesdt_pkg;

  localparam int unsigned AddrW       = 48;
  localparam int unsigned SlotW       = 6;
  localparam int unsigned TicksW      = 16;
  localparam int unsigned EventW      = 3;
  localparam int unsigned FuncW       = 2;
  localparam int unsigned InDataW     = 56;
  localparam int unsigned OutDataW    = 56;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 48;
  localparam int unsigned TableDepth  = 64;
  localparam logic [TicksW-1:0] TimeoutReset = 16'd5000;

  // input function codes
  localparam logic [FuncW-1:0] FUNC_REPORT = 2'd0;
  localparam logic [FuncW-1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_TICK   = 2'd2;

  // event codes
  localparam logic [EventW-1:0] EV_NEW_DEVICE = 3'd0;
  localparam logic [EventW-1:0] EV_NAME_UPGR  = 3'd1;
  localparam logic [EventW-1:0] EV_TABLE_FULL = 3'd2;
  localparam logic [EventW-1:0] EV_APPEARED   = 3'd3;
  localparam logic [EventW-1:0] EV_GONE       = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_WATCH_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TARGET     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT    = 2'd2;

  typedef enum logic [1:0] {
    CMD_SCAN,
    CMD_WATCH,
    CMD_CLEAR,
    CMD_TICK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [AddrW-1:0]  addr;
    logic              named;
    logic              complete;
  } cmd_t;

  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic              named;
    logic              complete;
  } slot_t;

  typedef struct packed {
    logic present;
    logic cd_zero;
  } back_status_t;

endpackage : blesdt_pkg
`default_nettype wire

// ----- hw/rtl/ble_scan_device_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ble_scan_device_table
// Advertising report table with single-target presence watch.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tdata: address, name flags; tuser: func
//   m_axis    out  tvalid/tready          tdata: slot, address, flags; tuser: event
//   cfg       in   cfg_we_i (no wait)     cfg_idx_i, cfg_wdata_i
//
// A clear, or a tick or watch report without a result, is done when it is
// popped; one with a result is popped, then loads the output register.
// A scan report walks the slot memory one entry per cycle through its
// single read port. Each transaction passes through a two-entry command
// queue; input stalls only while it is full. Reset clears the table count,
// presence, countdown and queue.
// ----------------------------------------------------------------------------
module ble_scan_device_table #(
  parameter int unsigned TABLE_DEPTH = blesdt_pkg::TableDepth
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [47:0] station_address, [48] name flag, [49] complete-name flag,
  // [55:50] zero
  input  wire logic [blesdt_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [1:0] func
  input  wire logic [blesdt_pkg::FuncW-1:0]     s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [5:0] slot_index, [53:6] report_address, [54] has_name,
  // [55] has_complete_name
  output logic [blesdt_pkg::OutDataW-1:0]       m_axis_tdata_o,
  // [2:0] event_code
  output logic [blesdt_pkg::EventW-1:0]         m_axis_tuser_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [blesdt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [blesdt_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import blesdt_pkg::*;

  logic              watch_mode_q;
  logic [AddrW-1:0]  target_q;
  logic [TicksW-1:0] timeout_q;

  logic         q_full, q_empty, q_push, q_pop;
  cmd_t         push_cmd, pop_cmd;
  back_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watch_mode_q <= 1'b0;
      target_q     <= '0;
      timeout_q    <= TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WATCH_MODE: watch_mode_q <= cfg_wdata_i[0];
        REG_TARGET:     target_q     <= cfg_wdata_i[AddrW-1:0];
        REG_TIMEOUT:    timeout_q    <= cfg_wdata_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  blesdt_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .watch_mode_i    (watch_mode_q),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  blesdt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (pop_cmd),
    .empty_o (q_empty)
  );

  blesdt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_cmd_i         (pop_cmd),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .target_i        (target_q),
    .timeout_i       (timeout_q),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .status_o        (status)
  );

`ifndef SYNTHESIS
  a_present_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.present |-> !status.cd_zero)
    else $error("target present with expired countdown");

  a_absent_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.present |-> status.cd_zero)
    else $error("countdown running while target absent");

  a_appeared_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(m_axis_tvalid_o) && (m_axis_tuser_o == EV_APPEARED)) |-> status.present)
    else $error("appeared event without target presence");
`endif

endmodule : ble_scan_device_table
`default_nettype wire

// ----- hw/rtl/blesdt_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// blesdt_front
// Input side: unpacks a stream transaction, classifies it into a table
// command and pushes it into the command queue.
// ----------------------------------------------------------------------------
module blesdt_front (
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [blesdt_pkg::InDataW-1:0] s_axis_tdata_i,
  input  wire logic [blesdt_pkg::FuncW-1:0]   s_axis_tuser_i,
  input  wire logic                          watch_mode_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output blesdt_pkg::cmd_t                   q_cmd_o
);
  import blesdt_pkg::*;

  logic known;

  always_comb begin
    q_cmd_o.addr     = s_axis_tdata_i[AddrW-1:0];
    q_cmd_o.named    = s_axis_tdata_i[AddrW];
    // a complete name only counts when a name was found at all
    q_cmd_o.complete = s_axis_tdata_i[AddrW+1] & s_axis_tdata_i[AddrW];
    known            = 1'b1;
    unique case (s_axis_tuser_i)
      FUNC_REPORT: q_cmd_o.kind = watch_mode_i ? CMD_WATCH : CMD_SCAN;
      FUNC_CLEAR:  q_cmd_o.kind = CMD_CLEAR;
      FUNC_TICK:   q_cmd_o.kind = CMD_TICK;
      default: begin
        q_cmd_o.kind = CMD_TICK;
        known        = 1'b0;
      end
    endcase
  end

  // unknown functions are taken and dropped
  assign s_axis_tready_o = ~q_full_i;
  assign q_push_o        = s_axis_tvalid_i & ~q_full_i & known;

endmodule : blesdt_front
`default_nettype wire

// ----- hw/rtl/blesdt_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// blesdt_queue
// Two-entry command queue between the input classifier and the table engine.
// ----------------------------------------------------------------------------
module blesdt_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire blesdt_pkg::cmd_t cmd_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output blesdt_pkg::cmd_t      cmd_o,
  output logic                  empty_o
);
  import blesdt_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign full_o  = fill_q == 2'd2;
  assign empty_o = fill_q == 2'd0;
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule : blesdt_queue
`default_nettype wire

// ----- hw/rtl/blesdt_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// blesdt_back
// Table engine: runs queued commands. Scan reports walk the slot memory one
// entry a cycle; watch reports and ticks drive the presence countdown.
// Results leave through a registered output stage.
// ----------------------------------------------------------------------------
module blesdt_back #(
  parameter int unsigned TABLE_DEPTH = blesdt_pkg::TableDepth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire blesdt_pkg::cmd_t                q_cmd_i,
  input  wire logic                            q_empty_i,
  output logic                                 q_pop_o,
  input  wire logic [blesdt_pkg::AddrW-1:0]    target_i,
  input  wire logic [blesdt_pkg::TicksW-1:0]   timeout_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic [blesdt_pkg::OutDataW-1:0]      m_axis_tdata_o,
  output logic [blesdt_pkg::EventW-1:0]        m_axis_tuser_o,
  output blesdt_pkg::back_status_t             status_o
);
  import blesdt_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]        state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   cmp_idx_q, cmp_idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic              present_q, present_d;
  logic [TicksW-1:0] cdown_q, cdown_d;

  logic [EventW-1:0] res_code_q, res_code_d;
  logic [SlotW-1:0]  res_slot_q, res_slot_d;
  logic [AddrW-1:0]  res_addr_q, res_addr_d;
  logic              res_named_q, res_named_d;
  logic              res_compl_q, res_compl_d;

  logic              out_vld_q, out_vld_d;
  logic [EventW-1:0] out_code_q;
  logic [SlotW-1:0]  out_slot_q;
  logic [AddrW-1:0]  out_addr_q;
  logic              out_named_q, out_compl_q;
  logic              out_load;

  slot_t             mem_q [TABLE_DEPTH];
  slot_t             rd_q;
  slot_t             wr_data;
  logic [IdxW-1:0]   wr_addr;
  logic              wr_en;
  logic              issue, hit, upgrade;

  assign issue   = idx_q < count_q;
  assign hit     = cmp_vld_q && (rd_q.addr == cmd_q.addr);
  assign upgrade = cmd_q.named && (!rd_q.named || (cmd_q.complete && !rd_q.complete));
  assign out_load = (state_q == ST_EMIT) && (!out_vld_q || m_axis_tready_i);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = cmp_vld_q;
    present_d   = present_q;
    cdown_d     = cdown_q;
    res_code_d  = res_code_q;
    res_slot_d  = res_slot_q;
    res_addr_d  = res_addr_q;
    res_named_d = res_named_q;
    res_compl_d = res_compl_q;
    q_pop_o     = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cmp_idx_q;
    wr_data     = '{addr: cmd_q.addr, named: cmd_q.named, complete: cmd_q.complete};

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o     = 1'b1;
          cmd_d       = q_cmd_i;
          res_slot_d  = '0;
          res_named_d = 1'b0;
          res_compl_d = 1'b0;
          case (q_cmd_i.kind)
            CMD_CLEAR: count_d = '0;
            CMD_TICK: begin
              if (present_q) begin
                if (cdown_q <= TicksW'(1)) begin
                  cdown_d    = '0;
                  present_d  = 1'b0;
                  res_code_d = EV_GONE;
                  res_addr_d = target_i;
                  state_d    = ST_EMIT;
                end else begin
                  cdown_d = cdown_q - TicksW'(1);
                end
              end
            end
            CMD_WATCH: begin
              if (q_cmd_i.addr == target_i) begin
                cdown_d = (timeout_i == '0) ? TicksW'(1) : timeout_i;
                if (!present_q) begin
                  present_d  = 1'b1;
                  res_code_d = EV_APPEARED;
                  res_addr_d = q_cmd_i.addr;
                  state_d    = ST_EMIT;
                end
              end
            end
            default: begin
              idx_d     = '0;
              cmp_vld_d = 1'b0;
              state_d   = ST_SEARCH;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        res_addr_d = cmd_q.addr;
        if (hit) begin
          if (upgrade) begin
            wr_en       = 1'b1;
            res_code_d  = EV_NAME_UPGR;
            res_slot_d  = SlotW'(cmp_idx_q);
            res_named_d = cmd_q.named;
            res_compl_d = cmd_q.complete;
            state_d     = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (!issue && !cmp_vld_q) begin
          // walked all stored slots without a match
          if (count_q == DepthCnt) begin
            res_code_d = EV_TABLE_FULL;
          end else begin
            wr_en       = 1'b1;
            wr_addr     = count_q[IdxW-1:0];
            count_d     = count_q + CntW'(1);
            res_code_d  = EV_NEW_DEVICE;
            res_slot_d  = SlotW'(count_q);
            res_named_d = cmd_q.named;
            res_compl_d = cmd_q.complete;
          end
          state_d = ST_EMIT;
        end else begin
          cmp_vld_d = issue;
          cmp_idx_d = idx_q[IdxW-1:0];
          if (issue) begin
            idx_d = idx_q + CntW'(1);
          end
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q & ~m_axis_tready_i;
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      present_q <= 1'b0;
      cdown_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      present_q <= present_d;
      cdown_q   <= cdown_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    cmp_idx_q   <= cmp_idx_d;
    res_code_q  <= res_code_d;
    res_slot_q  <= res_slot_d;
    res_addr_q  <= res_addr_d;
    res_named_q <= res_named_d;
    res_compl_q <= res_compl_d;
    if (out_load) begin
      out_code_q  <= res_code_q;
      out_slot_q  <= res_slot_q;
      out_addr_q  <= res_addr_q;
      out_named_q <= res_named_q;
      out_compl_q <= res_compl_q;
    end
  end

  // slot memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[idx_q[IdxW-1:0]];
  end

  assign m_axis_tvalid_o  = out_vld_q;
  assign m_axis_tuser_o   = out_code_q;
  assign m_axis_tdata_o   = {out_compl_q, out_named_q, out_addr_q, out_slot_q};
  assign status_o.present = present_q;
  assign status_o.cd_zero = cdown_q == '0;

endmodule : blesdt_back
`default_nettype wire

// ----- test/ble_scan_device_table_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ble_scan_device_table_tb
// Self-checking bench for the scan device table. A short table of directed
// transactions covers the edge cases. Random phases follow: scan mode with
// a small address pool or with wide addresses, and watch mode with short
// timeouts. Each phase runs its own register setting. Every event on the
// output stream is checked against an expected event queued at input.
// ----------------------------------------------------------------------------
module ble_scan_device_table_tb;
  import blesdt_pkg::*;

  localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [AddrW-1:0] ADDR_ONES   = 48'hFFFF_FFFF_FFFF;
  localparam logic [AddrW-1:0] TARGET_A    = 48'h1234_5678_9ABC;
  localparam int unsigned POOL_SIZE        = 80;
  localparam int unsigned SETTLE_CYCLES    = 300;
  localparam int unsigned HOLD_CYCLES      = 600;
  localparam int unsigned CYCLE_LIMIT      = 800000;

  typedef enum logic [1:0] {ROW_MODEL, ROW_QUIET, ROW_GIVEN, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {MIX_SCAN_POOL, MIX_SCAN_WIDE, MIX_WATCH} traffic_mix_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [AddrW-1:0] addr;
    logic             named;
    logic             complete;
  } adv_item_t;

  typedef struct packed {
    logic [EventW-1:0] code;
    logic [SlotW-1:0]  slot;
    logic [AddrW-1:0]  addr;
    logic              named;
    logic              complete;
  } dev_event_t;

  // ROW_CFG rows carry the register value in item.addr
  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] reg_idx;
    adv_item_t          item;
    dev_event_t         ev;
  } plan_row_t;

  typedef struct packed {
    logic              watch;
    logic [AddrW-1:0]  target;
    logic [TicksW-1:0] timeout;
    logic [15:0]       n_items;
    traffic_mix_e      mix;
    logic [3:0]        tx_gap;
    logic [3:0]        rx_gap;
  } phase_t;

  localparam dev_event_t NO_EVENT = '0;
  localparam int unsigned NUM_DIRECTED = 25;

  localparam plan_row_t DIRECTED [NUM_DIRECTED] = '{
    '{ROW_GIVEN, REG_WATCH_MODE, '{FUNC_REPORT, 48'h0, 1'b0, 1'b1},
      '{EV_NEW_DEVICE, 6'd0, 48'h0, 1'b0, 1'b0}},
    '{ROW_QUIET, REG_WATCH_MODE, '{FUNC_REPORT, 48'h0, 1'b0, 1'b0}, NO_EVENT},
    '{ROW_GIVEN, REG_WATCH_MODE, '{FUNC_REPORT, 48'h0, 1'b1, 1'b0},
      '{EV_NAME_UPGR, 6'd0, 48'h0, 1'b1, 1'b0}},
    '{ROW_GIVEN, REG_WATCH_MODE, '{FUNC_REPORT, 48'h0, 1'b1, 1'b1},
      '{EV_NAME_UPGR, 6'd0, 48'h0, 1'b1, 1'b1}},
    '{ROW_QUIET, REG_WATCH_MODE, '{FUNC_REPORT, 48'h0, 1'b1, 1'b1}, NO_EVENT},
    '{ROW_GIVEN, REG_WATCH_MODE, '{FUNC_REPORT, ADDR_ONES, 1'b1, 1'b1},
      '{EV_NEW_DEVICE, 6'd1, ADDR_ONES, 1'b1, 1'b1}},
    '{ROW_QUIET, REG_WATCH_MODE, '{FUNC_UNUSED, ADDR_ONES, 1'b1, 1'b1}, NO_EVENT},
    '{ROW_QUIET, REG_WATCH_MODE, '{FUNC_TICK, 48'h0, 1'b0, 1'b0}, NO_EVENT},
    '{ROW_QUIET, REG_WATCH_MODE, '{FUNC_CLEAR, 48'h0, 1'b0, 1'b0}, NO_EVENT},
    '{ROW_GIVEN, REG_WATCH_MODE, '{FUNC_REPORT, ADDR_ONES, 1'b0, 1'b0},
      '{EV_NEW_DEVICE, 6'd0, ADDR_ONES, 1'b0, 1'b0}},
    '{ROW_MODEL, REG_WATCH_MODE, '{FUNC_REPORT, 48'h5555_5555_5555, 1'b1, 1'b0}, NO_EVENT},
    '{ROW_MODEL, REG_WATCH_MODE, '{FUNC_REPORT, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b1}, NO_EVENT},
    '{ROW_CFG, REG_WATCH_MODE, '{FUNC_REPORT, 48'h1, 1'b0, 1'b0}, NO_EVENT},
    '{ROW_CFG, REG_TARGET, '{FUNC_REPORT, TARGET_A, 1'b0, 1'b0}, NO_EVENT},
    '{ROW_CFG, REG_TIMEOUT, '{FUNC_REPORT, 48'h2, 1'b0, 1'b0}, NO_EVENT},
    '{ROW_GIVEN, REG_WATCH_MODE, '{FUNC_REPORT, TARGET_A, 1'b1, 1'b1},
      '{EV_APPEARED, 6'd0, TARGET_A, 1'b0, 1'b0}},
    '{ROW_QUIET, REG_WATCH_MODE, '{FUNC_REPORT, ADDR_ONES, 1'b0, 1'b0}, NO_EVENT},
    '{ROW_MODEL, REG_WATCH_MODE, '{FUNC_REPORT, TARGET_A, 1'b0, 1'b0}, NO_EVENT},
    '{ROW_QUIET, REG_WATCH_MODE, '{FUNC_TICK, 48'h0, 1'b0, 1'b0}, NO_EVENT},
    '{ROW_GIVEN, REG_WATCH_MODE, '{FUNC_TICK, 48'h0, 1'b0, 1'b0},
      '{EV_GONE, 6'd0, TARGET_A, 1'b0, 1'b0}},
    '{ROW_MODEL, REG_WATCH_MODE, '{FUNC_REPORT, TARGET_A, 1'b1, 1'b0}, NO_EVENT},
    '{ROW_CFG, REG_WATCH_MODE, '{FUNC_REPORT, 48'h0, 1'b0, 1'b0}, NO_EVENT},
    '{ROW_MODEL, REG_WATCH_MODE, '{FUNC_TICK, 48'h0, 1'b0, 1'b0}, NO_EVENT},
    '{ROW_MODEL, REG_WATCH_MODE, '{FUNC_TICK, 48'h0, 1'b0, 1'b0}, NO_EVENT},
    '{ROW_MODEL, REG_WATCH_MODE, '{FUNC_REPORT, TARGET_A, 1'b1, 1'b0}, NO_EVENT}
  };

  localparam int unsigned NUM_PHASES = 6;
  localparam phase_t PHASES [NUM_PHASES] = '{
    '{1'b0, 48'h0, 16'd5000, 16'd320, MIX_SCAN_POOL, 4'd0, 4'd8},
    '{1'b1, 48'h3A5C_0F96_E271, 16'd3, 16'd260, MIX_WATCH, 4'd8, 4'd8},
    '{1'b1, 48'h0, 16'd0, 16'd160, MIX_WATCH, 4'd8, 4'd0},
    '{1'b0, ADDR_ONES, 16'd65535, 16'd260, MIX_SCAN_POOL, 4'd8, 4'd8},
    '{1'b1, ADDR_ONES, 16'd1, 16'd150, MIX_WATCH, 4'd0, 4'd0},
    '{1'b0, 48'h1, 16'd2, 16'd300, MIX_SCAN_WIDE, 4'd4, 4'd8}
  };

  // DUT connections
  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                s_valid = 1'b0;
  logic [InDataW-1:0]  s_data  = '0;
  logic [FuncW-1:0]    s_user  = FUNC_REPORT;
  logic                m_ready = 1'b0;
  logic                cfg_we  = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = REG_WATCH_MODE;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [EventW-1:0]   m_axis_tuser_o;

  // predictor state and register copies
  logic [AddrW-1:0]  tab_addr     [TableDepth];
  logic              tab_named    [TableDepth];
  logic              tab_complete [TableDepth];
  int unsigned       tab_count    = 0;
  logic              present      = 1'b0;
  logic [TicksW-1:0] cdown        = '0;
  logic              cfg_watch    = 1'b0;
  logic [AddrW-1:0]  cfg_target   = '0;
  logic [TicksW-1:0] cfg_timeout  = TimeoutReset;

  dev_event_t  pending_events [$];
  dev_event_t  got_ev;
  dev_event_t  want_ev;
  logic [AddrW-1:0] addr_pool [POOL_SIZE];

  int unsigned tx_gap_max = 0;
  int unsigned rx_gap_max = 0;
  int unsigned rx_wait    = 0;
  int unsigned hold_left  = 0;
  bit          hold_req   = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned items_sent  = 0;
  int unsigned events_seen = 0;
  int unsigned full_seen   = 0;
  int unsigned gone_seen   = 0;
  int unsigned reg_writes  = 0;

  ble_scan_device_table i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run stopped at cycle limit", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  // Table lookup, name upgrade and presence countdown for one transaction.
  function automatic bit predict_event(input adv_item_t it, output dev_event_t ev);
    logic        complete;
    bit          found;
    bit          emits;
    int unsigned i;
    complete = it.complete & it.named;
    found    = 1'b0;
    emits    = 1'b0;
    ev       = '0;
    case (it.func)
      FUNC_CLEAR: begin
        tab_count = 0;
      end
      FUNC_TICK: begin
        if (present) begin
          if (cdown <= 1) begin
            cdown   = '0;
            present = 1'b0;
            ev.code = EV_GONE;
            ev.addr = cfg_target;
            emits   = 1'b1;
          end else begin
            cdown = cdown - 1'b1;
          end
        end
      end
      FUNC_REPORT: begin
        if (cfg_watch) begin
          if (it.addr == cfg_target) begin
            cdown = (cfg_timeout == '0) ? 16'd1 : cfg_timeout;
            if (!present) begin
              present = 1'b1;
              ev.code = EV_APPEARED;
              ev.addr = it.addr;
              emits   = 1'b1;
            end
          end
        end else begin
          for (i = 0; i < tab_count; i++) begin
            if (!found && tab_addr[i] == it.addr) begin
              found = 1'b1;
              if (it.named && (!tab_named[i] || (complete && !tab_complete[i]))) begin
                tab_named[i]    = 1'b1;
                tab_complete[i] = complete;
                ev    = '{EV_NAME_UPGR, SlotW'(i), it.addr, 1'b1, complete};
                emits = 1'b1;
              end
            end
          end
          if (!found) begin
            if (tab_count >= TableDepth) begin
              ev.code = EV_TABLE_FULL;
              ev.addr = it.addr;
            end else begin
              tab_addr[tab_count]     = it.addr;
              tab_named[tab_count]    = it.named;
              tab_complete[tab_count] = complete;
              ev = '{EV_NEW_DEVICE, SlotW'(tab_count), it.addr, it.named, complete};
              tab_count++;
            end
            emits = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return emits;
  endfunction

  function automatic adv_item_t random_item(input traffic_mix_e mix);
    adv_item_t   it;
    int unsigned roll;
    roll        = $urandom_range(0, 999);
    it.func     = FUNC_REPORT;
    it.named    = 1'($urandom_range(0, 1));
    it.complete = 1'($urandom_range(0, 1));
    it.addr     = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 15) begin
      it.func = FUNC_UNUSED;
    end else if (mix == MIX_WATCH) begin
      if (roll < 60)       it.func = FUNC_CLEAR;
      else if (roll < 480) it.func = FUNC_TICK;
      else if (roll < 740) it.addr = cfg_target;
    end else begin
      if (roll < 20)       it.func = FUNC_CLEAR;
      else if (roll < 100) it.func = FUNC_TICK;
      else if (mix == MIX_SCAN_WIDE && roll < 900) it.addr = {16'($urandom), $urandom};
    end
    return it;
  endfunction

  task automatic check_field(input string what, input logic [AddrW-1:0] want,
                             input logic [AddrW-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  // output side: compare at the rising edge, pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got_ev = '{m_axis_tuser_o, m_axis_tdata_o[5:0], m_axis_tdata_o[53:6],
                 m_axis_tdata_o[54], m_axis_tdata_o[55]};
      events_seen++;
      if (got_ev.code == EV_TABLE_FULL) full_seen++;
      if (got_ev.code == EV_GONE) gone_seen++;
      if (pending_events.size() == 0) begin
        error_count++;
        $display("%0t: unexpected event, expected none, got code %0d slot %0d addr %h",
                 $time, got_ev.code, got_ev.slot, got_ev.addr);
      end else begin
        want_ev = pending_events.pop_front();
        check_field("event_code", 48'(want_ev.code), 48'(got_ev.code));
        check_field("slot_index", 48'(want_ev.slot), 48'(got_ev.slot));
        check_field("report_address", want_ev.addr, got_ev.addr);
        check_field("has_name", 48'(want_ev.named), 48'(got_ev.named));
        check_field("has_complete_name", 48'(want_ev.complete), 48'(got_ev.complete));
      end
      rx_wait = $urandom_range(0, rx_gap_max);
    end
  end

  // ready changes at the falling edge; a hold request stalls the output long
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Called and returns at a falling edge.
  task automatic send_item(input adv_item_t it, input row_kind_e kind,
                           input dev_event_t given);
    int unsigned gap;
    dev_event_t  ev;
    bit          emits;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {6'b0, it.complete, it.named, it.addr};
    s_user  <= it.func;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    emits = predict_event(it, ev);
    if (kind == ROW_GIVEN) pending_events.push_back(given);
    else if (kind == ROW_MODEL && emits) pending_events.push_back(ev);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_events();
    s_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // a report that yields no event may still be in flight: let it finish
  task automatic wait_idle();
    drain_events();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_WATCH_MODE: cfg_watch   = value[0];
      REG_TARGET:     cfg_target  = value;
      REG_TIMEOUT:    cfg_timeout = value[TicksW-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  initial begin : stimulus
    adv_item_t   it;
    int unsigned p;
    int unsigned n;
    addr_pool[0] = '0;
    addr_pool[1] = ADDR_ONES;
    for (p = 2; p < POOL_SIZE; p++) addr_pool[p] = {16'($urandom), $urandom};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_gap_max = 8;
    rx_gap_max = 8;
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(DIRECTED[r].reg_idx, DIRECTED[r].item.addr);
      end else begin
        send_item(DIRECTED[r].item, DIRECTED[r].kind, DIRECTED[r].ev);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_reg(REG_WATCH_MODE, 48'(PHASES[p].watch));
      write_reg(REG_TARGET, PHASES[p].target);
      write_reg(REG_TIMEOUT, 48'(PHASES[p].timeout));
      tx_gap_max = PHASES[p].tx_gap;
      rx_gap_max = PHASES[p].rx_gap;
      // back-to-back input against a stalled output fills the command queue
      if (p == 0) hold_req = 1'b1;
      for (n = 0; n < PHASES[p].n_items; n++) begin
        if (p == 3 && n == PHASES[p].n_items / 2) drain_events();
        it = random_item(PHASES[p].mix);
        send_item(it, ROW_MODEL, NO_EVENT);
      end
    end

    drain_events();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d transactions across scan and watch phases with %0d register writes.",
             items_sent, reg_writes);
    $display("Checked %0d events, %0d table-full and %0d target-gone among them.",
             events_seen, full_seen, gone_seen);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
